@@ rtl/ftnds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftnds_pkg
// Shared widths, codes and types for the far-to-near depth sort list.
// ----------------------------------------------------------------------------
package ftnds_pkg;

    // Number of cells in the sorted chain (2 to 64).
    localparam int LIST_DEPTH = 64;

    localparam int COORD_W  = 20;
    localparam int HANDLE_W = 12;
    localparam int KEY_W    = 46;
    localparam int KIND_W   = 2;
    localparam int AXES     = 3;
    // Doubled difference per axis, signed, and its magnitude.
    localparam int DIFF_W   = COORD_W + 3;
    localparam int MAG_W    = DIFF_W - 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int CNT_W    = $clog2(LIST_DEPTH + 1);

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [KEY_W-1:0]          key_t;
    typedef logic [HANDLE_W-1:0]       handle_t;
    typedef logic [CNT_W-1:0]          count_t;

    // Operation codes of an input transaction.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_INS_OK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CAMERA_X = 2'd0;
    localparam logic [1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [1:0] REG_CAMERA_Z = 2'd2;

    // One stored list entry.
    typedef struct packed {
        key_t    key;
        handle_t handle;
    } entry_t;

    // Load enables of the distance pipeline stages.
    typedef struct packed {
        logic ld_diff;
        logic ld_sq;
        logic ld_key;
    } dist_ctl_t;

    // Chain commands, common to every cell.
    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

endpackage : ftnds_pkg
`default_nettype wire

@@ rtl/ftnds_dist.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftnds_dist
// Three-stage squared-distance pipeline: doubled difference, square, sum.
// ----------------------------------------------------------------------------
module ftnds_dist
    import ftnds_pkg::*;
(
    input  wire logic      aclk,
    input  wire dist_ctl_t ctl,
    input  wire coord_t    cam     [AXES],
    input  wire coord_t    box_max [AXES],
    input  wire coord_t    box_min [AXES],
    input  wire coord_t    pos     [AXES],
    output key_t           key
);

    logic [MAG_W-1:0] mag_reg [AXES];
    logic [SQ_W-1:0]  sq_reg  [AXES];
    key_t             key_reg;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] neg;

        // Twice the camera-to-centre difference, exact in 1/16 units.
        assign diff = (DIFF_W'(cam[a]) <<< 1)
                    - (DIFF_W'(box_max[a]) + DIFF_W'(box_min[a]))
                    - (DIFF_W'(pos[a]) <<< 1);
        assign neg  = -diff;

        always_ff @(posedge aclk) begin
            if (ctl.ld_diff) begin
                mag_reg[a] <= diff[DIFF_W-1] ? neg[MAG_W-1:0] : diff[MAG_W-1:0];
            end
            if (ctl.ld_sq) begin
                sq_reg[a] <= mag_reg[a] * mag_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_key) begin
            key_reg <= KEY_W'(sq_reg[0]) + KEY_W'(sq_reg[1]) + KEY_W'(sq_reg[2]);
        end
    end

    assign key = key_reg;

endmodule : ftnds_dist
`default_nettype wire

@@ rtl/ftnds_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ftnds_cell
// One slot of the sorted chain: keeps, takes new or prior entry, or shifts.
// ----------------------------------------------------------------------------
module ftnds_cell
    import ftnds_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occ,
    input  wire entry_t    new_entry,
    input  wire logic      prev_lt,
    input  wire entry_t    prev_entry,
    input  wire entry_t    next_entry,
    output logic           lt,
    output entry_t         entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // A free slot, or a stored key strictly below the new one, gives way.
    // Equal keys stay ahead so that arrival order is kept.
    assign lt = !occ || (entry_reg.key < new_entry.key);

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift) begin
            entry_next = next_entry;
        end else if (ctl.ins && lt) begin
            entry_next = prev_lt ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : ftnds_cell
`default_nettype wire

@@ rtl/far_to_near_depth_sort_list_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// far_to_near_depth_sort_list_top
// Depth sort list: keeps entity handles ordered farthest first from a camera.
// ----------------------------------------------------------------------------
// An insert transaction passes from acceptance through the doubled
// difference, the squares and their sum in the distance pipeline, and then
// the chain of cells, which compares every stored key with the new key at
// once and opens a gap; it completes once the result register is free. A
// drain transaction has the head cell of the chain hand out one entry per
// cycle, while the result register is free, into the single result
// register; an empty list gives one empty result. The block works on one
// transaction at a time; a finished result waiting in the result register
// does not stop the next transaction being accepted.
// ----------------------------------------------------------------------------
module far_to_near_depth_sort_list_top
    import ftnds_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic      [PDATA_W-1:0]    prdata,
    output logic                       pready,

    // Input transactions.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [HANDLE_W-1:0]   s_entity_handle,
    input  wire logic signed [COORD_W-1:0] s_box_max_x,
    input  wire logic signed [COORD_W-1:0] s_box_max_y,
    input  wire logic signed [COORD_W-1:0] s_box_max_z,
    input  wire logic signed [COORD_W-1:0] s_box_min_x,
    input  wire logic signed [COORD_W-1:0] s_box_min_y,
    input  wire logic signed [COORD_W-1:0] s_box_min_z,
    input  wire logic signed [COORD_W-1:0] s_pos_x,
    input  wire logic signed [COORD_W-1:0] s_pos_y,
    input  wire logic signed [COORD_W-1:0] s_pos_z,

    // Result transactions.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [KIND_W-1:0]     m_kind,
    output logic      [HANDLE_W-1:0]   m_out_handle,
    output logic      [KEY_W-1:0]      m_sort_key,
    output logic                       m_last
);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIFF  = 5'b00010,
        ST_SQ    = 5'b00100,
        ST_INS   = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    handle_t handle_reg;

    coord_t  cam_x_reg, cam_y_reg, cam_z_reg;

    logic                m_valid_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    handle_t             m_handle_reg;
    key_t                m_key_reg;
    logic                m_last_reg;

    logic        s_accept;
    logic        out_free;
    logic        load_out;
    logic [KIND_W-1:0] out_kind;
    handle_t     out_handle;
    key_t        out_key;
    logic        out_last;
    logic        list_full;

    dist_ctl_t   dist_ctl;
    cell_ctl_t   cell_ctl;
    key_t        new_key;
    entry_t      new_entry;

    coord_t      cam_v     [AXES];
    coord_t      box_max_v [AXES];
    coord_t      box_min_v [AXES];
    coord_t      pos_v     [AXES];

    entry_t      cell_q  [LIST_DEPTH];
    logic        cell_lt [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] occ;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; the
    // port never inserts wait states. Reads return the sign-extended value.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_CAMERA_X: cam_x_reg <= pwdata[COORD_W-1:0];
                REG_CAMERA_Y: cam_y_reg <= pwdata[COORD_W-1:0];
                REG_CAMERA_Z: cam_z_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CAMERA_X: prdata = PDATA_W'(cam_x_reg);
            REG_CAMERA_Y: prdata = PDATA_W'(cam_y_reg);
            REG_CAMERA_Z: prdata = PDATA_W'(cam_z_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Distance pipeline. Each stage loads only in its own step of the
    // sequence, so the key is held for as long as the insert is stalled.
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign cam_v     = '{cam_x_reg, cam_y_reg, cam_z_reg};
    assign box_max_v = '{s_box_max_x, s_box_max_y, s_box_max_z};
    assign box_min_v = '{s_box_min_x, s_box_min_y, s_box_min_z};
    assign pos_v     = '{s_pos_x, s_pos_y, s_pos_z};

    assign dist_ctl.ld_diff = s_accept && (s_op == OP_INSERT);
    assign dist_ctl.ld_sq   = (state_reg == ST_DIFF);
    assign dist_ctl.ld_key  = (state_reg == ST_SQ);

    ftnds_dist u_dist (
        .aclk    (aclk),
        .ctl     (dist_ctl),
        .cam     (cam_v),
        .box_max (box_max_v),
        .box_min (box_min_v),
        .pos     (pos_v),
        .key     (new_key)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            handle_reg <= s_entity_handle;
        end
    end

    assign new_entry.key    = new_key;
    assign new_entry.handle = handle_reg;

    // ------------------------------------------------------------------
    // Chain of cells. Cell 0 holds the farthest entry. The entry count
    // marks which cells hold live entries; on an insert every cell at or
    // past the insertion point moves one place back, and on a drain the
    // whole chain moves one place towards the head.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_chain
        entry_t prev_e;
        entry_t next_e;
        logic   prev_l;

        assign occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign prev_e = new_entry;
            assign prev_l = 1'b0;
        end else begin : g_body
            assign prev_e = cell_q[i-1];
            assign prev_l = cell_lt[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_tail
            assign next_e = cell_q[i];
        end else begin : g_inner
            assign next_e = cell_q[i+1];
        end

        ftnds_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .occ        (occ[i]),
            .new_entry  (new_entry),
            .prev_lt    (prev_l),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .lt         (cell_lt[i]),
            .entry      (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer. The result register is free when empty or being taken.
    // ------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign list_full = (count_reg == CNT_W'(LIST_DEPTH));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cell_ctl   = '0;
        load_out   = 1'b0;
        out_kind   = KIND_INS_OK;
        out_handle = '0;
        out_key    = new_key;
        out_last   = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_op == OP_DRAIN) ? ST_DRAIN : ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = ST_SQ;
            end
            ST_SQ: begin
                state_next = ST_INS;
            end
            ST_INS: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (list_full) begin
                        out_kind = KIND_FULL;
                    end else begin
                        cell_ctl.ins = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (count_reg == '0) begin
                        out_kind   = KIND_EMPTY;
                        out_key    = '0;
                        state_next = ST_IDLE;
                    end else begin
                        out_kind       = KIND_ENTRY;
                        out_handle     = cell_q[0].handle;
                        out_key        = cell_q[0].key;
                        out_last       = (count_reg == CNT_W'(1));
                        cell_ctl.shift = 1'b1;
                        count_next     = count_reg - 1'b1;
                        if (count_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_kind_reg   <= out_kind;
            m_handle_reg <= out_handle;
            m_key_reg    <= out_key;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_out_handle = m_handle_reg;
    assign m_sort_key   = m_key_reg;
    assign m_last       = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_ins_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctl.ins |-> (count_reg < CNT_W'(LIST_DEPTH)))
        else $error("chain insert on a full list");

    a_ins_shift_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cell_ctl.ins && cell_ctl.shift))
        else $error("insert and shift in the same cycle");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && out_kind == KIND_ENTRY && out_last) |=>
            (count_reg == '0 && state_reg == ST_IDLE))
        else $error("list not empty after final drained entry");

endmodule : far_to_near_depth_sort_list_top
`default_nettype wire
